[design/trle_pkg.sv]
package trle_pkg;

    localparam logic [1:0] FN_BYTE  = 2'd0;
    localparam logic [1:0] FN_OPEN  = 2'd1;
    localparam logic [1:0] FN_CLOSE = 2'd2;

    localparam logic [1:0] K_BYTE  = 2'd0;
    localparam logic [1:0] K_CHAR  = 2'd1;
    localparam logic [1:0] K_END   = 2'd2;
    localparam logic [1:0] K_CLOSE = 2'd3;

    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] TELOPT_ECHO = 8'd1;
    localparam logic [7:0] OPT_SGA  = 8'd3;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_GT  = 8'h3E;

    typedef enum logic [1:0] {
        PS_NORMAL = 2'd0,
        PS_IAC    = 2'd1,
        PS_OPT    = 2'd2,
        PS_SB     = 2'd3
    } t_pstate;

    // emit sequences
    typedef enum logic [3:0] {
        SQ_NONE, SQ_OPEN, SQ_FULL, SQ_REPLY, SQ_BS, SQ_ECHO, SQ_ECHO2, SQ_NL
    } t_seq;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOK, ST_READ, ST_EMIT, ST_LINE, ST_TAIL
    } t_state;

    // per-connection control record kept in the context memory
    typedef struct packed {
        logic       in_use;
        logic [7:0] owner;
        t_pstate    pstate;
        logic [7:0] verb;
        logic [5:0] len;
    } t_ctx;

endpackage

[design/telnet_rx_line_editor_unit.sv]
// Receive engine for up to CONNS Telnet connections. Beats enter on start while busy is
// low; results leave one per cycle on o_valid and cannot be stalled, o_last marks the final
// one of an item. The connection table is a synchronous context memory walked one entry per
// cycle on each item before the first result; results then stream one per cycle, and line
// delivery reads the line memory one character per cycle.
module telnet_rx_line_editor_unit
    import trle_pkg::*;
#(
    parameter int CONNS      = 4,
    parameter int LINE_BYTES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_func,
    input  logic [7:0] i_slot,
    input  logic [7:0] i_data,
    output logic       o_valid,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_slot,
    output logic [3:0] o_entry,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    localparam int EW = (CONNS > 1) ? $clog2(CONNS) : 1;
    localparam int CW = $clog2(CONNS + 1);
    localparam int AW = $clog2(CONNS * LINE_BYTES);

    t_ctx            ctx_mem [CONNS];
    logic [7:0]      line_mem [CONNS * LINE_BYTES];
    logic [CONNS-1:0] r_valid_e;

    logic            r_cfg;
    t_state          r_st, n_st;
    logic [1:0]      r_func;
    logic [7:0]      r_slot, r_data;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_found, n_found;
    logic            r_free, n_free;
    logic [EW-1:0]   r_hit, n_hit, r_fr, n_fr;
    t_ctx            r_rd;
    logic [7:0]      r_ld;
    t_seq            r_seq, n_seq;
    logic [3:0]      r_k, n_k;
    logic [7:0]      r_rep, n_rep;
    logic [5:0]      r_pos, n_pos;
    logic [5:0]      r_llen, n_llen;

    logic            ctx_we;
    logic [EW-1:0]   ctx_wa;
    t_ctx            ctx_wd;
    logic            ln_we;
    logic [AW-1:0]   ln_wa, ln_ra;
    logic [EW-1:0]   ctx_ra;

    logic            ov;
    logic [1:0]      okind;
    logic [7:0]      obyte;
    logic            olast;
    logic            ochar;

    always_ff @(posedge i_clk) begin
        if (ctx_we) ctx_mem[ctx_wa] <= ctx_wd;
        r_rd <= ctx_mem[ctx_ra];
        if (ln_we) line_mem[ln_wa] <= r_data;
        r_ld <= line_mem[ln_ra];
    end

    function automatic logic [AW-1:0] laddr(logic [EW-1:0] e, logic [5:0] p);
        logic [AW+7:0] a;
        a = (AW + 8)'(e) * (AW + 8)'(LINE_BYTES) + (AW + 8)'(p);
        return a[AW-1:0];
    endfunction

    assign busy = (r_st != ST_IDLE);

    always_comb begin
        t_ctx c;
        logic [7:0] b;
        c = r_rd;
        b = r_data;
        n_st = r_st; n_idx = r_idx; n_found = r_found; n_free = r_free;
        n_hit = r_hit; n_fr = r_fr; n_seq = r_seq; n_k = r_k; n_rep = r_rep;
        n_pos = r_pos; n_llen = r_llen;
        ctx_we = 1'b0; ctx_wa = r_hit; ctx_wd = r_rd;
        ln_we = 1'b0; ln_wa = laddr(r_hit, r_rd.len);
        ln_ra = laddr(r_hit, r_pos);
        ctx_ra = r_idx[EW-1:0];
        ov = 1'b0; okind = K_BYTE; obyte = 8'd0; olast = 1'b0; ochar = 1'b0;
        unique case (r_st)
            ST_IDLE: begin
                if (start) begin
                    n_st = ST_LOOK; n_idx = '0; n_found = 1'b0; n_free = 1'b0;
                end
            end
            ST_LOOK: begin
                // r_rd holds entry r_idx-1 once r_idx > 0
                if (r_idx != '0) begin
                    if (!(r_valid_e[r_idx[EW-1:0] - EW'(1)] && r_rd.in_use)) begin
                        if (!r_free) begin
                            n_free = 1'b1; n_fr = r_idx[EW-1:0] - EW'(1);
                        end
                    end else if (r_rd.owner == r_slot && !r_found) begin
                        n_found = 1'b1; n_hit = r_idx[EW-1:0] - EW'(1);
                    end
                end
                if (r_idx == CW'(CONNS)) begin
                    n_st = ST_READ;
                    ctx_ra = n_hit;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            ST_READ: begin
                n_st = ST_IDLE; n_seq = SQ_NONE; n_k = '0;
                unique case (r_func)
                    FN_OPEN: begin
                        n_st = ST_EMIT;
                        if (!r_free) n_seq = SQ_FULL;
                        else begin
                            n_seq = SQ_OPEN; n_hit = r_fr;
                            ctx_we = 1'b1; ctx_wa = r_fr;
                            ctx_wd = '{in_use: 1'b1, owner: r_slot, pstate: PS_NORMAL,
                                       verb: 8'd0, len: 6'd0};
                        end
                    end
                    FN_CLOSE: begin
                        if (r_found) begin
                            ctx_we = 1'b1; c.in_use = 1'b0; ctx_wd = c;
                        end
                    end
                    FN_BYTE: begin
                        if (r_found) begin
                            ctx_we = 1'b1;
                            case (r_rd.pstate)
                                PS_NORMAL, PS_IAC: begin
                                    logic ed;
                                    ed = 1'b0;
                                    if (r_rd.pstate == PS_NORMAL) begin
                                        if (b == B_IAC) c.pstate = PS_IAC;
                                        else ed = 1'b1;
                                    end else if (b == B_SB) c.pstate = PS_SB;
                                    else if (b == B_WILL || b == B_WONT || b == B_DO ||
                                             b == B_DONT) begin
                                        c.verb = b; c.pstate = PS_OPT;
                                    end else begin
                                        c.pstate = PS_NORMAL;
                                        ed = (b == B_IAC);
                                    end
                                    if (ed) begin
                                        if (b == CH_LF) begin
                                            n_seq = SQ_NL; n_st = ST_EMIT;
                                            n_llen = r_rd.len; n_pos = '0;
                                            c.len = '0;
                                        end else if (b == CH_BS || b == CH_DEL) begin
                                            if (r_rd.len != '0) begin
                                                c.len = r_rd.len - 6'd1;
                                                n_seq = SQ_BS; n_st = ST_EMIT;
                                            end
                                        end else if (b >= CH_SP &&
                                                     r_rd.len < 6'(LINE_BYTES - 1)) begin
                                            ln_we = 1'b1;
                                            c.len = r_rd.len + 6'd1;
                                            n_seq = (b == B_IAC) ? SQ_ECHO2 : SQ_ECHO;
                                            n_st = ST_EMIT;
                                        end
                                    end
                                end
                                PS_OPT: begin
                                    c.pstate = PS_NORMAL;
                                    if (r_rd.verb == B_DO && b != TELOPT_ECHO && b != OPT_SGA)
                                    begin
                                        n_rep = B_WONT; n_seq = SQ_REPLY; n_st = ST_EMIT;
                                    end else if (r_rd.verb == B_WILL) begin
                                        n_rep = B_DONT; n_seq = SQ_REPLY; n_st = ST_EMIT;
                                    end
                                end
                                default: if (b == B_SE) c.pstate = PS_NORMAL;
                            endcase
                            ctx_wd = c;
                        end
                    end
                    default: ;
                endcase
            end
            ST_EMIT: begin
                ov = 1'b1; n_k = r_k + 4'd1;
                case (r_seq)
                    SQ_FULL: begin okind = K_CLOSE; olast = 1'b1; end
                    SQ_OPEN: begin
                        case (r_k)
                            4'd0, 4'd3: obyte = B_IAC;
                            4'd1, 4'd4: obyte = B_WILL;
                            4'd2: obyte = TELOPT_ECHO;
                            4'd5: obyte = OPT_SGA;
                            4'd6: obyte = CH_GT;
                            default: begin obyte = CH_SP; olast = 1'b1; end
                        endcase
                    end
                    SQ_REPLY: begin
                        case (r_k)
                            4'd0: obyte = B_IAC;
                            4'd1: obyte = r_rep;
                            default: begin obyte = r_data; olast = 1'b1; end
                        endcase
                    end
                    SQ_BS: begin
                        obyte = (r_k == 4'd1) ? CH_SP : CH_BS;
                        olast = (r_k == 4'd2);
                    end
                    SQ_ECHO: begin obyte = r_data; olast = 1'b1; end
                    SQ_ECHO2: begin obyte = B_IAC; olast = (r_k == 4'd1); end
                    default: begin
                        // new line: CR LF, then line/prompt
                        obyte = (r_k == 4'd0) ? CH_CR : CH_LF;
                        if (r_k == 4'd1) begin
                            n_k = '0;
                            if (r_cfg) begin
                                n_st = ST_LINE; ln_ra = laddr(r_hit, 6'd0);
                                n_pos = 6'd1;
                            end else n_st = ST_TAIL;
                        end
                    end
                endcase
                if (olast) n_st = ST_IDLE;
            end
            ST_LINE: begin
                // r_ld holds char r_pos-1 when r_pos <= llen
                ov = 1'b1; ochar = 1'b1;
                if (r_pos <= r_llen) begin
                    okind = K_CHAR; obyte = r_ld;
                    ln_ra = laddr(r_hit, r_pos);
                    n_pos = r_pos + 6'd1;
                end else begin
                    okind = K_END; n_st = ST_TAIL;
                end
            end
            ST_TAIL: begin
                ov = 1'b1; n_k = r_k + 4'd1;
                obyte = (r_k == 4'd0) ? CH_GT : CH_SP;
                olast = (r_k != 4'd0);
                if (olast) n_st = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_cfg <= 1'b0; r_valid_e <= '0; o_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) r_cfg <= i_cfg_data;
            if (ctx_we) r_valid_e[ctx_wa] <= 1'b1;
            o_valid <= ov;
        end
        if (start && !busy) begin
            r_func <= i_func; r_slot <= i_slot; r_data <= i_data;
        end
        r_idx <= n_idx; r_found <= n_found; r_free <= n_free; r_hit <= n_hit;
        r_fr <= n_fr; r_seq <= n_seq; r_k <= n_k; r_rep <= n_rep;
        r_pos <= n_pos; r_llen <= n_llen;
        o_kind <= okind; o_out_slot <= r_slot; o_out_byte <= obyte; o_last <= olast;
        o_entry <= ochar ? 4'(r_hit) : 4'd0;
    end

endmodule
